@@ hdl/srbm_pkg.sv @@
`default_nettype none
package srbm_pkg;
    localparam int MaxRadiusDefault = 1024;
    localparam int CoordW = 11;
    localparam int RadW = 11;
    localparam int HardW = 9;
    localparam int AlphaW = 8;
    localparam int SqW = 23;             // dx^2+dy^2 < 2^23 (coords 11 bits)
    localparam int RootW = 20;           // isqrt of SqW+16 bits
    localparam int RemW = RootW + 2;
    localparam int QuoW = 9;             // quotient bits; >255 clamps
    localparam int NumW = 27;            // 255*(256R - r) fits
    localparam int DenW = 20;            // R*(256-h)
    localparam logic [0:0] RegRadius = 1'b0;
    localparam logic [0:0] RegHardness = 1'b1;
    localparam logic [AlphaW-1:0] AlphaOpaque = 8'hFF;
    localparam logic [AlphaW-1:0] AlphaClear = 8'h00;

    typedef struct packed {
        logic [1:0]        kind;        // 0 falloff, 1 opaque, 2 clear
        logic [NumW-1:0]   num;
        logic [DenW-1:0]   den;
    } div_req_t;

    localparam logic [1:0] KindFall = 2'd0;
    localparam logic [1:0] KindOpaque = 2'd1;
    localparam logic [1:0] KindClear = 2'd2;
endpackage
`default_nettype wire

@@ hdl/srbm_sqrt_cell.sv @@
`default_nettype none
// One restoring square-root step: one result bit per cell.
module srbm_sqrt_cell (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic [2*srbm_pkg::RootW-1:0]   rad_in,
    input  wire logic [srbm_pkg::RemW-1:0]      rem_in,
    input  wire logic [srbm_pkg::RootW-1:0]     root_in,
    output logic [2*srbm_pkg::RootW-1:0]        rad_out,
    output logic [srbm_pkg::RemW-1:0]           rem_out,
    output logic [srbm_pkg::RootW-1:0]          root_out
);
    logic [srbm_pkg::RemW-1:0] rem_sh;
    logic [srbm_pkg::RemW-1:0] trial;
    logic                      fit;

    always_comb begin
        rem_sh = {rem_in[srbm_pkg::RemW-3:0], rad_in[2*srbm_pkg::RootW-1 -: 2]};
        trial  = {root_in, 2'b01};
        fit    = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_out  <= {rad_in[2*srbm_pkg::RootW-3:0], 2'b00};
            rem_out  <= fit ? rem_sh - trial : rem_sh;
            root_out <= {root_in[srbm_pkg::RootW-2:0], fit};
        end
    end
endmodule
`default_nettype wire

@@ hdl/srbm_div_cell.sv @@
`default_nettype none
// One restoring division step: one quotient bit per cell.
module srbm_div_cell (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire srbm_pkg::div_req_t        req_in,
    input  wire logic [srbm_pkg::DenW:0]   rem_in,
    input  wire logic [srbm_pkg::QuoW-1:0] quo_in,
    input  wire logic                      bit_in,
    input  wire logic                      ovf_in,
    output srbm_pkg::div_req_t             req_out,
    output logic [srbm_pkg::DenW:0]        rem_out,
    output logic [srbm_pkg::QuoW-1:0]      quo_out,
    output logic                           ovf_out
);
    logic [srbm_pkg::DenW+1:0] sh;
    logic                      fit;

    always_comb begin
        sh  = {rem_in, bit_in};
        fit = sh >= {2'b00, req_in.den};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            req_out <= req_in;
            rem_out <= fit ? (srbm_pkg::DenW+1)'(sh - {2'b00, req_in.den})
                           : sh[srbm_pkg::DenW:0];
            quo_out <= {quo_in[srbm_pkg::QuoW-2:0], fit};
            ovf_out <= ovf_in | quo_in[srbm_pkg::QuoW-1];
        end
    end
endmodule
`default_nettype wire

@@ hdl/soft_round_brush_mask_unit.sv @@
`default_nettype none
// Channel   | dir | tdata fields (low bit up)          | side
// s_axis    | in  | pos_x[10:0], pos_y[21:11], pad to 24 | tvalid/tready
// m_axis    | out | alpha[7:0]                          | tvalid/tready
// cfg       | in  | index 0 brush_radius, 1 hardness     | cfg_valid/cfg_ready
//
// One pixel per cycle, back to back, while the output is not stalled. From input beat to output beat the stages are:
// 2 (deltas, squares), 20 (sqrt cells), 2 (classify, scale), 27 (divide cells), 1 (out).
// The whole chain moves together; a stalled output stalls every cell.
// aresetn is synchronous, active low, clears valid bits and sets the brush registers to radius 16, hardness 0;
// both tready and cfg_ready are low while it is held.
// Config must be written only while the pipeline is empty.
module soft_round_brush_mask_unit #(
    parameter int MaxRadius = srbm_pkg::MaxRadiusDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,    // pos_x, pos_y
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // alpha
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    localparam int RW = srbm_pkg::RootW;
    localparam int NW = srbm_pkg::NumW;
    localparam int DW = srbm_pkg::DenW;
    localparam int SW = srbm_pkg::SqW;
    localparam int Depth = 2 + RW + 2 + NW;

    logic [srbm_pkg::RadW-1:0]  radius_reg;
    logic [srbm_pkg::HardW-1:0] hard_reg;
    logic [srbm_pkg::RadW-1:0]  r_eff;
    logic [srbm_pkg::HardW-1:0] h_eff;
    logic [Depth-1:0]           vld_reg;
    logic                       adv;
    logic [7:0]                 out_reg;
    logic                       out_vld_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 11'd16;
            hard_reg   <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == srbm_pkg::RegRadius) radius_reg <= cfg_data;
            else                                  hard_reg   <= cfg_data[8:0];
        end
    end

    always_comb begin
        r_eff = radius_reg;
        if (radius_reg == '0) r_eff = 11'd1;
        else if (32'(radius_reg) > MaxRadius) r_eff = srbm_pkg::RadW'(MaxRadius);
        h_eff = (hard_reg > 9'd256) ? 9'd256 : hard_reg;
    end

    // pipeline advances when the output slot is free or draining
    assign adv = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    // stage 1: abs deltas
    logic [10:0] dx_reg, dy_reg;
    logic [10:0] px, py;
    assign px = s_axis_tdata[10:0];
    assign py = s_axis_tdata[21:11];
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= (px >= r_eff) ? px - r_eff : r_eff - px;
            dy_reg <= (py >= r_eff) ? py - r_eff : r_eff - py;
        end
    end

    // stage 2: sum of squares, scaled by 2^16 for 8 fraction bits of root
    logic [2*RW-1:0] rad0_reg;
    always_ff @(posedge aclk) begin
        if (adv) rad0_reg <= {1'b0, SW'(dx_reg) * SW'(dx_reg) + SW'(dy_reg) * SW'(dy_reg),
                              16'd0};
    end

    // sqrt chain
    logic [2*RW-1:0]               rad_c  [RW+1];
    logic [srbm_pkg::RemW-1:0]     rem_c  [RW+1];
    logic [RW-1:0]                 root_c [RW+1];
    assign rad_c[0]  = rad0_reg;
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;
    for (genvar i = 0; i < RW; i++) begin : g_sq
        srbm_sqrt_cell u_cell (
            .aclk(aclk), .en(adv),
            .rad_in(rad_c[i]), .rem_in(rem_c[i]), .root_in(root_c[i]),
            .rad_out(rad_c[i+1]), .rem_out(rem_c[i+1]), .root_out(root_c[i+1])
        );
    end

    // stage: classify, form numerator and denominator
    srbm_pkg::div_req_t req_a_reg;
    logic [RW-1:0] dist_val;
    logic [19:0]   outer, core;
    assign dist_val = root_c[RW];
    assign outer    = {r_eff, 8'd0} & 20'hFFFFF;
    assign core     = 20'(r_eff) * 20'(h_eff);
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dist_val > outer)       req_a_reg.kind <= srbm_pkg::KindClear;
            else if (dist_val <= core)  req_a_reg.kind <= srbm_pkg::KindOpaque;
            else                        req_a_reg.kind <= srbm_pkg::KindFall;
            req_a_reg.num <= NW'(outer - dist_val);
            req_a_reg.den <= DW'(r_eff) * DW'(9'd256 - h_eff);
        end
    end

    srbm_pkg::div_req_t req_b_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            req_b_reg.kind <= req_a_reg.kind;
            req_b_reg.den  <= req_a_reg.den;
            req_b_reg.num  <= NW'(req_a_reg.num * 8'd255);
        end
    end

    // divide chain, numerator bits fed MSB first
    srbm_pkg::div_req_t        dq   [NW+1];
    logic [DW:0]               drem [NW+1];
    logic [srbm_pkg::QuoW-1:0] dquo [NW+1];
    logic                      dovf [NW+1];
    logic [NW-1:0]             nsh  [NW+1];
    assign dq[0]   = req_b_reg;
    assign drem[0] = '0;
    assign dquo[0] = '0;
    assign dovf[0] = 1'b0;
    assign nsh[0]  = req_b_reg.num;
    for (genvar j = 0; j < NW; j++) begin : g_dv
        srbm_div_cell u_cell (
            .aclk(aclk), .en(adv), .req_in(dq[j]), .rem_in(drem[j]),
            .quo_in(dquo[j]), .bit_in(nsh[j][NW-1-j]), .ovf_in(dovf[j]),
            .req_out(dq[j+1]), .rem_out(drem[j+1]), .quo_out(dquo[j+1]),
            .ovf_out(dovf[j+1])
        );
        assign nsh[j+1] = dq[j+1].num;
    end

    logic [7:0] alpha;
    always_comb begin
        unique case (dq[NW].kind)
            srbm_pkg::KindClear:  alpha = srbm_pkg::AlphaClear;
            srbm_pkg::KindOpaque: alpha = srbm_pkg::AlphaOpaque;
            default: alpha = (dovf[NW] || dquo[NW][8]) ? srbm_pkg::AlphaOpaque
                                                        : dquo[NW][7:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (adv) out_vld_reg <= vld_reg[Depth-1];
        if (adv) out_reg <= alpha;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;
endmodule
`default_nettype wire

@@ hdl/srbm_checker.sv @@
`default_nettype none
module srbm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while chain stalled");
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind soft_round_brush_mask_unit srbm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
